// ----- rtl/fsh_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed session handshake package
// Shared transaction types, codes and command descriptors.
// ----------------------------------------------------------------------------
`default_nettype none
package fsh_pkg;

    typedef enum logic [2:0] {
        OP_RX     = 3'd0,
        OP_START  = 3'd1,
        OP_TICK   = 3'd2,
        OP_CLOSED = 3'd3,
        OP_REJECT = 3'd4
    } op_t;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_APP   = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_VERIFIED = 3'd1;
    localparam logic [2:0] EV_REJECTED = 3'd2;
    localparam logic [2:0] EV_DISCONN  = 3'd3;
    localparam logic [2:0] EV_CLOSEREQ = 3'd4;

    localparam logic [2:0] ST_CONNECTED  = 3'd0;
    localparam logic [2:0] ST_HELLO_SENT = 3'd1;
    localparam logic [2:0] ST_AWAIT      = 3'd2;
    localparam logic [2:0] ST_VERIFIED   = 3'd3;
    localparam logic [2:0] ST_GOAWAY     = 3'd4;
    localparam logic [2:0] ST_CLOSED     = 3'd5;

    localparam logic [7:0] TYPE_HELLO    = 8'h01;
    localparam logic [7:0] TYPE_VERIFIED = 8'h02;
    localparam logic [7:0] TYPE_GOAWAY   = 8'h03;
    localparam logic [31:0] HELLO_LEN    = 32'd25;

    localparam logic [7:0] WHY_SELF     = 8'd1;
    localparam logic [7:0] WHY_CLUSTER  = 8'd2;
    localparam logic [7:0] WHY_DUP      = 8'd3;
    localparam logic [7:0] WHY_PROTOCOL = 8'd4;
    localparam logic [7:0] WHY_TIMEOUT  = 8'd5;

    localparam logic [2:0] REG_RUN     = 3'd0;
    localparam logic [2:0] REG_CLUSTER = 3'd1;
    localparam logic [2:0] REG_NODE    = 3'd2;
    localparam logic [2:0] REG_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_MAXLEN  = 3'd4;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] rx_byte;
        logic       peer_duplicate;
        logic [7:0] reject_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [2:0]  event_code;
        logic        last;
        logic [2:0]  session_state;
        logic [7:0]  reject_reason;
        logic [63:0] peer_run_id;
        logic [63:0] peer_cluster_id;
        logic [63:0] peer_node_id;
        logic        peer_id_valid;
    } out_item_t;

    // One command from the front to the back: a sequence of result segments.
    // Segments are emitted in order: app/empty byte, VERIFIED frame, HELLO
    // frame, GOAWAY frame, first event, second event. Status is the snapshot
    // after the transaction.
    typedef struct packed {
        logic        app;       // single application byte or empty message
        logic [1:0]  app_kind;
        logic [7:0]  app_byte;
        logic        app_last;
        logic        ver;       // VERIFIED frame, 5 bytes
        logic        hello;     // HELLO frame, 29 bytes
        logic        goaway;    // GOAWAY frame, 6 bytes
        logic [7:0]  why;
        logic [2:0]  ev1;
        logic [2:0]  ev2;
        logic [2:0]  session_state;
        logic [7:0]  reject_reason;
        logic [63:0] peer_run_id;
        logic [63:0] peer_cluster_id;
        logic [63:0] peer_node_id;
        logic        peer_id_valid;
        logic [63:0] hello_run;
        logic [63:0] hello_cluster;
        logic [63:0] hello_node;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/fsh_front.sv -----
// ----------------------------------------------------------------------------
// Framed session handshake front end
// Parses received bytes, runs the session state machine and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module fsh_front
    import fsh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire in_item_t in_item,
    input  wire logic     in_fire,
    output cmd_t          cmd,
    output logic          cmd_emit
);

    logic [63:0] run_reg, cluster_reg, node_reg;
    logic [31:0] timeout_reg, maxlen_reg;
    logic [2:0]  st_reg, st_next;
    logic [7:0]  why_reg, why_next;
    logic        open_reg, open_next;
    logic [2:0]  hc_reg, hc_next;
    logic [31:0] flen_reg, flen_next;
    logic [31:0] pc_reg, pc_next;
    logic [7:0]  mt_reg, mt_next;
    logic [63:0] stg_reg [3];
    logic [63:0] stg_next [3];
    logic [63:0] pid_reg [3];
    logic [63:0] pid_next [3];
    logic        pv_reg, pv_next;
    logic        arm_reg, arm_next;
    logic [31:0] tc_reg, tc_next;
    cmd_t        c;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [31:0] fl;
        logic [31:0] idx;
        logic [4:0]  sh;
        logic        rej;
        logic [7:0]  rwhy;
        logic [1:0]  sel;
        st_next = st_reg; why_next = why_reg; open_next = open_reg;
        hc_next = hc_reg; flen_next = flen_reg; pc_next = pc_reg; mt_next = mt_reg;
        stg_next = stg_reg; pid_next = pid_reg; pv_next = pv_reg;
        arm_next = arm_reg; tc_next = tc_reg;
        rej = 1'b0; rwhy = 8'd0; fl = 32'd0; idx = 32'd0; sh = 5'd0; sel = 2'd0;
        c = '0;
        case (in_item.operation)
            OP_RX:
            begin
                if (st_reg != ST_GOAWAY && st_reg != ST_CLOSED) begin
                    if (hc_reg < 3'd4) begin
                        fl = (hc_reg == 3'd0) ? 32'd0 : flen_reg;
                        sh = {hc_reg[1:0], 3'b000};
                        fl = fl | ({24'd0, in_item.rx_byte} << sh);
                        flen_next = fl;
                        hc_next = hc_reg + 3'd1;
                        if (hc_reg == 3'd3) begin
                            stg_next[0] = '0; stg_next[1] = '0; stg_next[2] = '0;
                            pc_next = '0; mt_next = '0;
                            if (fl > maxlen_reg) begin
                                rej = 1'b1; rwhy = WHY_PROTOCOL;
                            end else if (fl == 32'd0) begin
                                hc_next = '0;
                                if (st_reg == ST_VERIFIED) begin
                                    c.app = 1'b1; c.app_kind = KIND_EMPTY; c.app_last = 1'b1;
                                end else begin
                                    rej = 1'b1; rwhy = WHY_PROTOCOL;
                                end
                            end
                        end
                    end else begin
                        idx = pc_reg;
                        pc_next = pc_reg + 32'd1;
                        if (st_reg == ST_VERIFIED) begin
                            c.app = 1'b1; c.app_kind = KIND_APP;
                            c.app_byte = in_item.rx_byte;
                            c.app_last = (pc_next == flen_reg);
                            if (pc_next == flen_reg) hc_next = '0;
                        end else begin
                            if (idx == 32'd0) mt_next = in_item.rx_byte;
                            else if (idx <= 32'd24) begin
                                idx = idx - 32'd1;
                                sel = idx[4:3];
                                stg_next[sel] = stg_reg[sel] |
                                    ({56'd0, in_item.rx_byte} << {idx[2:0], 3'b000});
                            end
                            if (pc_next == flen_reg) begin
                                hc_next = '0;
                                if (mt_next == TYPE_HELLO) begin
                                    if (st_reg != ST_AWAIT) begin
                                        if (flen_reg < HELLO_LEN) begin
                                            rej = 1'b1; rwhy = WHY_PROTOCOL;
                                        end else begin
                                            pid_next = stg_next; pv_next = 1'b1;
                                            if (stg_next[0] == run_reg) begin
                                                rej = 1'b1; rwhy = WHY_SELF;
                                            end else if (stg_next[1] != cluster_reg) begin
                                                rej = 1'b1; rwhy = WHY_CLUSTER;
                                            end else if (in_item.peer_duplicate) begin
                                                rej = 1'b1; rwhy = WHY_DUP;
                                            end else if (!open_reg) begin
                                                rej = 1'b1; rwhy = WHY_PROTOCOL;
                                            end else begin
                                                c.ver = 1'b1;
                                                c.hello = (st_reg == ST_CONNECTED);
                                                st_next = ST_AWAIT;
                                            end
                                        end
                                    end
                                end else if (mt_next == TYPE_VERIFIED) begin
                                    if (st_reg != ST_AWAIT) begin
                                        rej = 1'b1; rwhy = WHY_PROTOCOL;
                                    end else begin
                                        arm_next = 1'b0; st_next = ST_VERIFIED;
                                        c.ev1 = EV_VERIFIED;
                                    end
                                end else if (mt_next == TYPE_GOAWAY) begin
                                    if (flen_reg >= 32'd2) why_next = stg_next[0][7:0];
                                    st_next = ST_CLOSED;
                                    c.ev1 = EV_REJECTED;
                                end else begin
                                    rej = 1'b1; rwhy = WHY_PROTOCOL;
                                end
                            end
                        end
                    end
                end
            end
            OP_START:
            begin
                if (st_reg == ST_CONNECTED) begin
                    if (timeout_reg != 32'd0) begin
                        arm_next = 1'b1; tc_next = timeout_reg;
                    end
                    if (open_reg) begin
                        c.hello = 1'b1; st_next = ST_HELLO_SENT;
                    end
                end
            end
            OP_TICK:
            begin
                if (arm_reg) begin
                    tc_next = (tc_reg != 32'd0) ? tc_reg - 32'd1 : tc_reg;
                    if (tc_next == 32'd0) begin
                        arm_next = 1'b0;
                        if (st_reg <= ST_AWAIT) begin
                            rej = 1'b1; rwhy = WHY_TIMEOUT;
                        end
                    end
                end
            end
            OP_CLOSED:
            begin
                open_next = 1'b0; arm_next = 1'b0; st_next = ST_CLOSED;
                c.ev1 = EV_DISCONN;
            end
            OP_REJECT:
            begin
                rej = 1'b1; rwhy = in_item.reject_code;
            end
            default:
            begin
            end
        endcase
        // Rejection overrides any partial effects except peer id capture.
        if (rej && st_reg != ST_GOAWAY && st_reg != ST_CLOSED) begin
            c.ver = 1'b0; c.hello = 1'b0; c.app = 1'b0;
            c.goaway = open_reg; c.why = rwhy;
            st_next = ST_GOAWAY; why_next = rwhy;
            hc_next = '0; pc_next = '0;
            c.ev1 = EV_REJECTED;
            c.ev2 = open_reg ? EV_CLOSEREQ : EV_NONE;
            open_next = 1'b0;
        end
        c.session_state = st_next;
        c.reject_reason = why_next;
        c.peer_run_id = pid_next[0];
        c.peer_cluster_id = pid_next[1];
        c.peer_node_id = pid_next[2];
        c.peer_id_valid = pv_next;
        c.hello_run = run_reg;
        c.hello_cluster = cluster_reg;
        c.hello_node = node_reg;
    end

    assign cmd = c;
    assign cmd_emit = c.app | c.ver | c.hello | c.goaway | (c.ev1 != EV_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg <= '0; cluster_reg <= '0; node_reg <= '0;
            timeout_reg <= 32'd5000; maxlen_reg <= 32'd67108864;
            st_reg <= ST_CONNECTED; why_reg <= '0; open_reg <= 1'b1;
            hc_reg <= '0; flen_reg <= '0; pc_reg <= '0; mt_reg <= '0;
            stg_reg[0] <= '0; stg_reg[1] <= '0; stg_reg[2] <= '0;
            pid_reg[0] <= '0; pid_reg[1] <= '0; pid_reg[2] <= '0;
            pv_reg <= 1'b0; arm_reg <= 1'b0; tc_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_RUN:     run_reg <= cfg_data;
                    REG_CLUSTER: cluster_reg <= cfg_data;
                    REG_NODE:    node_reg <= cfg_data;
                    REG_TIMEOUT: timeout_reg <= cfg_data[31:0];
                    REG_MAXLEN:  maxlen_reg <= cfg_data[31:0];
                    default:     ;
                endcase
            end
            if (in_fire) begin
                st_reg <= st_next; why_reg <= why_next; open_reg <= open_next;
                hc_reg <= hc_next; flen_reg <= flen_next; pc_reg <= pc_next;
                mt_reg <= mt_next; stg_reg <= stg_next; pid_reg <= pid_next;
                pv_reg <= pv_next; arm_reg <= arm_next; tc_reg <= tc_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fsh_back.sv -----
// ----------------------------------------------------------------------------
// Framed session handshake back end
// Expands one command into its sequence of result transactions.
// ----------------------------------------------------------------------------
`default_nettype none
module fsh_back
    import fsh_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  cmd,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    output out_item_t  out_item,
    output logic       out_valid,
    input  wire logic  out_ready
);

    // Segment codes in emission order.
    typedef enum logic [2:0] {
        SEG_APP, SEG_VER, SEG_HELLO, SEG_GOAWAY, SEG_EV1, SEG_EV2, SEG_DONE
    } seg_t;

    seg_t       seg_reg;
    logic [4:0] pos_reg;
    logic       busy_reg;
    out_item_t  o;
    logic       seg_last;
    seg_t       nxt;
    seg_t       seg_cur;
    logic [4:0] pos_cur;

    function automatic logic seg_on(input cmd_t cm, input seg_t s);
        case (s)
            SEG_APP:    seg_on = cm.app;
            SEG_VER:    seg_on = cm.ver;
            SEG_HELLO:  seg_on = cm.hello;
            SEG_GOAWAY: seg_on = cm.goaway;
            SEG_EV1:    seg_on = (cm.ev1 != EV_NONE);
            SEG_EV2:    seg_on = (cm.ev2 != EV_NONE);
            default:    seg_on = 1'b0;
        endcase
    endfunction

    function automatic seg_t seg_after(input cmd_t cm, input seg_t s);
        seg_t r;
        r = SEG_DONE;
        if (s < SEG_EV2 && seg_on(cm, SEG_EV2)) r = SEG_EV2;
        if (s < SEG_EV1 && seg_on(cm, SEG_EV1)) r = SEG_EV1;
        if (s < SEG_GOAWAY && seg_on(cm, SEG_GOAWAY)) r = SEG_GOAWAY;
        if (s < SEG_HELLO && seg_on(cm, SEG_HELLO)) r = SEG_HELLO;
        if (s < SEG_VER && seg_on(cm, SEG_VER)) r = SEG_VER;
        return r;
    endfunction

    always_comb
    begin
        logic [191:0] ids;
        logic [4:0]   k;
        // A fresh command is decoded combinationally and starts at its first segment.
        seg_cur = busy_reg ? seg_reg : (cmd.app ? SEG_APP : seg_after(cmd, SEG_APP));
        pos_cur = busy_reg ? pos_reg : 5'd0;
        ids = {cmd.hello_node, cmd.hello_cluster, cmd.hello_run};
        k = pos_cur - 5'd5;
        o = '0;
        o.session_state = cmd.session_state;
        o.reject_reason = cmd.reject_reason;
        o.peer_run_id = cmd.peer_run_id;
        o.peer_cluster_id = cmd.peer_cluster_id;
        o.peer_node_id = cmd.peer_node_id;
        o.peer_id_valid = cmd.peer_id_valid;
        seg_last = 1'b1;
        case (seg_cur)
            SEG_APP:
            begin
                o.kind = cmd.app_kind; o.data_byte = cmd.app_byte; o.last = cmd.app_last;
            end
            SEG_VER:
            begin
                o.kind = KIND_TX;
                o.data_byte = (pos_cur == 5'd0) ? 8'd1 :
                              (pos_cur == 5'd4) ? TYPE_VERIFIED : 8'd0;
                o.last = (pos_cur == 5'd4);
                seg_last = o.last;
            end
            SEG_HELLO:
            begin
                o.kind = KIND_TX;
                if (pos_cur == 5'd0) o.data_byte = HELLO_LEN[7:0];
                else if (pos_cur < 5'd4) o.data_byte = 8'd0;
                else if (pos_cur == 5'd4) o.data_byte = TYPE_HELLO;
                else o.data_byte = ids[{k, 3'b000} +: 8];
                o.last = (pos_cur == 5'd28);
                seg_last = o.last;
            end
            SEG_GOAWAY:
            begin
                o.kind = KIND_TX;
                o.data_byte = (pos_cur == 5'd0) ? 8'd2 :
                              (pos_cur == 5'd4) ? TYPE_GOAWAY :
                              (pos_cur == 5'd5) ? cmd.why : 8'd0;
                o.last = (pos_cur == 5'd5);
                seg_last = o.last;
            end
            SEG_EV1:
            begin
                o.kind = KIND_EVENT; o.event_code = cmd.ev1;
                o.last = !seg_on(cmd, SEG_EV2);
            end
            SEG_EV2:
            begin
                o.kind = KIND_EVENT; o.event_code = cmd.ev2; o.last = 1'b1;
            end
            default: ;
        endcase
        nxt = seg_after(cmd, seg_cur);
    end

    assign out_item  = o;
    assign out_valid = cmd_valid;
    assign cmd_ready = out_valid && out_ready && seg_last && (nxt == SEG_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seg_reg <= SEG_APP; pos_reg <= '0; busy_reg <= 1'b0;
        end else if (out_valid && out_ready) begin
            if (!seg_last) begin
                busy_reg <= 1'b1; seg_reg <= seg_cur; pos_reg <= pos_cur + 5'd1;
            end
            else if (nxt == SEG_DONE) busy_reg <= 1'b0;
            else begin
                busy_reg <= 1'b1; seg_reg <= nxt; pos_reg <= '0;
            end
        end
    end

    a_done_pops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> out_valid && out_ready)
        else $error("command popped without final transaction");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg <= 5'd28)
        else $error("frame position out of range");
    a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cmd_valid)
        else $error("back end busy without a command");

endmodule
`default_nettype wire

// ----- rtl/fsh_queue.sv -----
// ----------------------------------------------------------------------------
// Framed session handshake command queue
// Small FIFO of commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module fsh_queue
    import fsh_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t wr_data,
    input  wire logic wr_en,
    output logic      full,
    output cmd_t      rd_data,
    output logic      rd_valid,
    input  wire logic rd_en
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t              mem_reg [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_en) rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/framed_session_handshake.sv -----
// ----------------------------------------------------------------------------
// Framed session handshake
// Length-prefixed frame parser and session handshake engine.
// ----------------------------------------------------------------------------
// Usage: input transactions carry received bytes, start, tick, close and
// local reject operations. The front end takes one input transaction per
// cycle while the queue is not full, updates the session state in the same
// cycle and pushes a command into a short queue whenever that input produces
// results. The back end expands each command into one to 34 output
// transactions, one per cycle while the receiver is ready: application bytes,
// transmit frames (VERIFIED 5, HELLO 29, GOAWAY 6 bytes) and events. Inputs
// that produce one result sustain one per cycle while the receiver is ready;
// a frame burst holds the input off once the queue of QUEUE_DEPTH commands
// fills. Reset sets state connected with the connection open and the
// registers to their defaults. When the receiver stalls, output holds steady
// and the input is taken until the queue is full. The configuration port is
// always ready and must be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module framed_session_handshake
    import fsh_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item
);

    cmd_t fr_cmd, q_cmd;
    logic fr_emit, q_full, q_valid, bk_ready, in_fire;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    fsh_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_item(in_item), .in_fire(in_fire),
        .cmd(fr_cmd), .cmd_emit(fr_emit)
    );

    fsh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_data(fr_cmd), .wr_en(in_fire && fr_emit), .full(q_full),
        .rd_data(q_cmd), .rd_valid(q_valid), .rd_en(bk_ready)
    );

    fsh_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(bk_ready),
        .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_fire)
        else $error("queue written while full");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output changed while stalled");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ready |-> q_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// ----- tb/framed_session_handshake_test.sv -----
// ----------------------------------------------------------------------------
// Framed session handshake testbench
// Drives random and directed handshake traffic through the block, predicts
// every output transaction with an internal session model and compares them
// field by field in the order they leave the block.
// ----------------------------------------------------------------------------
`default_nettype none
module framed_session_handshake_test;
    import fsh_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;

    framed_session_handshake u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Shadow copy of the registers and of the session state.
    logic [63:0] m_run_id, m_cluster_id, m_node_id;
    logic [31:0] m_timeout, m_max_len;
    logic [2:0]  m_state;
    logic [7:0]  m_reason, m_msg_type;
    logic        m_open, m_peer_valid, m_timer_on;
    logic [2:0]  m_hdr_count;
    logic [31:0] m_frame_len, m_pay_count, m_timer;
    logic [63:0] m_staged [3];
    logic [63:0] m_peer [3];

    // Results of the transaction being predicted, then the expected stream.
    out_item_t   step_results [$];
    out_item_t   expected_out [$];
    in_item_t    pending_in [$];

    int          mismatches;
    int          n_in_accepted;
    int          n_out_seen;
    int          idle_cycles;
    bit          hold_off;
    bit          stim_done;
    bit          in_taken;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void push_result(logic [1:0] kind, logic [7:0] data,
                                        logic [2:0] ev, logic last);
        out_item_t r;
        r = '0;
        r.kind = kind;
        r.data_byte = data;
        r.event_code = ev;
        r.last = last;
        step_results.push_back(r);
    endfunction

    function automatic bit send_frame(logic [7:0] bytes [], int len);
        if (!m_open)
            return 1'b0;
        for (int i = 0; i < 4; i++)
            push_result(KIND_TX, 8'(len >> (8 * i)), EV_NONE, 1'b0);
        for (int i = 0; i < len; i++)
            push_result(KIND_TX, bytes[i], EV_NONE, i + 1 == len);
        return 1'b1;
    endfunction

    function automatic bit send_hello();
        logic [7:0]  msg [];
        logic [63:0] ids [3];
        msg = new[25];
        ids[0] = m_run_id;
        ids[1] = m_cluster_id;
        ids[2] = m_node_id;
        msg[0] = TYPE_HELLO;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 8; i++)
                msg[1 + 8 * k + i] = ids[k][8 * i +: 8];
        return send_frame(msg, 25);
    endfunction

    // Sends GOAWAY when possible, moves to goaway sent and asks to close.
    function automatic void reject_session(logic [7:0] why);
        logic [7:0] msg [];
        if (m_state == ST_GOAWAY || m_state == ST_CLOSED)
            return;
        msg = new[2];
        msg[0] = TYPE_GOAWAY;
        msg[1] = why;
        void'(send_frame(msg, 2));
        m_state = ST_GOAWAY;
        m_reason = why;
        m_hdr_count = 0;
        m_pay_count = 0;
        push_result(KIND_EVENT, 8'h00, EV_REJECTED, 1'b0);
        if (m_open)
        begin
            m_open = 1'b0;
            push_result(KIND_EVENT, 8'h00, EV_CLOSEREQ, 1'b0);
        end
    endfunction

    // Acts on a complete handshake frame.
    function automatic void close_handshake_frame(logic dup);
        logic [7:0] msg [];
        if (m_msg_type == TYPE_HELLO)
        begin
            if (m_state == ST_AWAIT)
                return;
            if (m_frame_len < HELLO_LEN)
            begin
                reject_session(WHY_PROTOCOL);
                return;
            end
            for (int k = 0; k < 3; k++)
                m_peer[k] = m_staged[k];
            m_peer_valid = 1'b1;
            if (m_peer[0] == m_run_id)
            begin
                reject_session(WHY_SELF);
                return;
            end
            if (m_peer[1] != m_cluster_id)
            begin
                reject_session(WHY_CLUSTER);
                return;
            end
            if (dup)
            begin
                reject_session(WHY_DUP);
                return;
            end
            msg = new[1];
            msg[0] = TYPE_VERIFIED;
            if (!send_frame(msg, 1))
            begin
                reject_session(WHY_PROTOCOL);
                return;
            end
            if (m_state == ST_CONNECTED && !send_hello())
            begin
                reject_session(WHY_PROTOCOL);
                return;
            end
            m_state = ST_AWAIT;
        end
        else if (m_msg_type == TYPE_VERIFIED)
        begin
            if (m_state != ST_AWAIT)
            begin
                reject_session(WHY_PROTOCOL);
                return;
            end
            m_timer_on = 1'b0;
            m_state = ST_VERIFIED;
            push_result(KIND_EVENT, 8'h00, EV_VERIFIED, 1'b0);
        end
        else if (m_msg_type == TYPE_GOAWAY)
        begin
            if (m_frame_len >= 2)
                m_reason = m_staged[0][7:0];
            m_state = ST_CLOSED;
            push_result(KIND_EVENT, 8'h00, EV_REJECTED, 1'b0);
        end
        else
            reject_session(WHY_PROTOCOL);
    endfunction

    function automatic void take_rx_byte(logic [7:0] b, logic dup);
        logic [31:0] idx;
        if (m_state == ST_GOAWAY || m_state == ST_CLOSED)
            return;
        if (m_hdr_count < 4)
        begin
            if (m_hdr_count == 0)
                m_frame_len = 0;
            m_frame_len = m_frame_len | (32'(b) << (8 * m_hdr_count));
            m_hdr_count++;
            if (m_hdr_count < 4)
                return;
            for (int k = 0; k < 3; k++)
                m_staged[k] = '0;
            m_pay_count = 0;
            m_msg_type = 0;
            if (m_frame_len > m_max_len)
            begin
                reject_session(WHY_PROTOCOL);
                return;
            end
            if (m_frame_len == 0)
            begin
                m_hdr_count = 0;
                if (m_state == ST_VERIFIED)
                    push_result(KIND_EMPTY, 8'h00, EV_NONE, 1'b1);
                else
                    reject_session(WHY_PROTOCOL);
            end
            return;
        end
        idx = m_pay_count;
        m_pay_count++;
        if (m_state == ST_VERIFIED)
        begin
            push_result(KIND_APP, b, EV_NONE, m_pay_count == m_frame_len);
            if (m_pay_count == m_frame_len)
                m_hdr_count = 0;
            return;
        end
        if (idx == 0)
            m_msg_type = b;
        else if (idx <= 24)
            m_staged[(idx - 1) >> 3] = m_staged[(idx - 1) >> 3]
                                       | (64'(b) << (8 * ((idx - 1) & 7)));
        if (m_pay_count == m_frame_len)
        begin
            m_hdr_count = 0;
            close_handshake_frame(dup);
        end
    endfunction

    // Predicts the results of one input transaction and queues them.
    function automatic void predict_session(in_item_t it);
        step_results.delete();
        case (it.operation)
            OP_RX:
                take_rx_byte(it.rx_byte, it.peer_duplicate);
            OP_START:
                if (m_state == ST_CONNECTED)
                begin
                    if (m_timeout > 0)
                    begin
                        m_timer_on = 1'b1;
                        m_timer = m_timeout;
                    end
                    if (send_hello())
                        m_state = ST_HELLO_SENT;
                end
            OP_TICK:
                if (m_timer_on)
                begin
                    if (m_timer > 0)
                        m_timer--;
                    if (m_timer == 0)
                    begin
                        m_timer_on = 1'b0;
                        if (m_state <= ST_AWAIT)
                            reject_session(WHY_TIMEOUT);
                    end
                end
            OP_CLOSED:
            begin
                m_open = 1'b0;
                m_timer_on = 1'b0;
                m_state = ST_CLOSED;
                push_result(KIND_EVENT, 8'h00, EV_DISCONN, 1'b0);
            end
            OP_REJECT:
                reject_session(it.reject_code);
            default:
            begin
            end
        endcase
        if (step_results.size() > 0 && step_results[$].kind == KIND_EVENT)
            step_results[$].last = 1'b1;
        foreach (step_results[k])
        begin
            step_results[k].session_state = m_state;
            step_results[k].reject_reason = m_reason;
            step_results[k].peer_run_id = m_peer[0];
            step_results[k].peer_cluster_id = m_peer[1];
            step_results[k].peer_node_id = m_peer[2];
            step_results[k].peer_id_valid = m_peer_valid;
            expected_out.push_back(step_results[k]);
        end
    endfunction

    function automatic void reset_session();
        m_run_id = '0;
        m_cluster_id = '0;
        m_node_id = '0;
        m_timeout = 32'd5000;
        m_max_len = 32'd67108864;
        m_state = ST_CONNECTED;
        m_reason = '0;
        m_open = 1'b1;
        m_hdr_count = '0;
        m_frame_len = '0;
        m_pay_count = '0;
        m_msg_type = '0;
        m_peer_valid = 1'b0;
        m_timer_on = 1'b0;
        m_timer = '0;
        for (int k = 0; k < 3; k++)
        begin
            m_staged[k] = '0;
            m_peer[k] = '0;
        end
    endfunction

    // Driver: one transaction at a time from the pending queue, some of them
    // held back by random idle gaps. Acceptance is taken from the rising
    // edge, where the predictor flags it.
    int send_gap;
    initial send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                void'(pending_in.pop_front());
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
            end
            if (in_taken || !in_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_in.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_item <= pending_in[0];
                end
                else
                    in_valid <= 1'b0;
            end
            in_taken = 1'b0;
        end
    end

    // Predictor hook: every accepted input transaction is modeled here.
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
        begin
            predict_session(in_item);
            n_in_accepted++;
            in_taken = 1'b1;
        end

    // Receiver readiness: random stalls after accepted outputs, or a long
    // hold-off when the stimulus asks for one.
    int recv_gap;
    initial recv_gap = 0;
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
                recv_gap = $urandom_range(0, 4) == 0 ? $urandom_range(0, 10) : 0;
        end
    end

    // Monitor: compare each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && out_valid && out_ready)
        begin
            n_out_seen++;
            if (expected_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction %p", out_item);
            end
            else
            begin
                exp_item = expected_out.pop_front();
                if (out_item !== exp_item)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at output %0d:\n  expected %p\n  actual   %p",
                                 n_out_seen, exp_item, out_item);
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction is accepted on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Queue helpers for the stimulus.
    task automatic queue_op(op_t op, logic [7:0] b, logic dup, logic [7:0] code);
        in_item_t it;
        it.operation = op;
        it.rx_byte = b;
        it.peer_duplicate = dup;
        it.reject_code = code;
        pending_in.push_back(it);
    endtask

    task automatic queue_byte(logic [7:0] b);
        queue_op(OP_RX, b, $urandom_range(0, 1), 8'($urandom));
    endtask

    task automatic queue_header(logic [31:0] len);
        for (int i = 0; i < 4; i++)
            queue_byte(len[8 * i +: 8]);
    endtask

    // A HELLO frame from the peer with the given ids and duplicate answer.
    task automatic queue_hello(logic [63:0] run, logic [63:0] clus, logic [63:0] node,
                               logic dup, int len);
        logic [7:0] body [25];
        body[0] = TYPE_HELLO;
        for (int i = 0; i < 8; i++)
        begin
            body[1 + i] = run[8 * i +: 8];
            body[9 + i] = clus[8 * i +: 8];
            body[17 + i] = node[8 * i +: 8];
        end
        queue_header(32'(len));
        for (int i = 0; i < len; i++)
            queue_op(OP_RX, i < 25 ? body[i] : 8'($urandom), i == len - 1 ? dup : 1'b0,
                     8'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_in.size() > 0 || in_valid || expected_out.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RUN:     m_run_id = value;
            REG_CLUSTER: m_cluster_id = value;
            REG_NODE:    m_node_id = value;
            REG_TIMEOUT: m_timeout = value[31:0];
            REG_MAXLEN:  m_max_len = value[31:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Queues session traffic: the only way back to connected is a reset, so
    // a full handshake from scratch happens once per reset, and closing
    // cannot re-reach connected. Sessions therefore run in sequence within
    // one state lifetime.
    task automatic random_session(int n_items, logic [63:0] run, logic [63:0] clus);
        int pick;
        logic [31:0] len;
        if ($urandom_range(0, 1))
            queue_op(OP_START, 8'h00, 1'b0, 8'h00);
        queue_hello($urandom_range(0, 7) == 0 ? run : {$urandom, $urandom},
                    $urandom_range(0, 7) == 0 ? ~clus : clus, {$urandom, $urandom},
                    $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0 ? 26 : 25);
        queue_header(32'd1);
        queue_byte($urandom_range(0, 9) == 0 ? TYPE_GOAWAY : TYPE_VERIFIED);
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = $urandom_range(0, 9) == 0 ? 32'd0 : 32'($urandom_range(1, 6));
                queue_header(len);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom));
                n += len;
            end
            else if (pick < 85)
                queue_op(OP_TICK, 8'h00, 1'b0, 8'h00);
            else if (pick < 95)
                queue_byte(8'($urandom));
            else if (pick < 97)
                queue_op(op_t'($urandom_range(5, 7)), 8'($urandom), 1'b0, 8'($urandom));
            else if (pick < 99)
                queue_op(OP_REJECT, 8'h00, 1'b0, 8'($urandom));
            else
                queue_op(OP_CLOSED, 8'h00, 1'b0, 8'h00);
        end
    endtask

    // Resets are not repeated, so each phase begins in whatever state the
    // previous one left; the session state machine never returns to
    // connected. The verified data path reached from scratch is only
    // possible once, hence phase one covers the connected path through to
    // verified traffic and the rest exercise rejects on the ended session.
    initial
    begin
        logic [63:0] run_id;
        logic [63:0] clus_id;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        mismatches = 0;
        n_in_accepted = 0;
        n_out_seen = 0;
        idle_cycles = 0;
        reset_session();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extreme register values first, then the working setting.
        write_reg(REG_RUN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CLUSTER, 64'h0);
        write_reg(REG_NODE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
        write_reg(REG_MAXLEN, 64'hFFFF_FFFF);
        run_id = {$urandom, $urandom};
        clus_id = {$urandom, $urandom};
        write_reg(REG_RUN, run_id);
        write_reg(REG_CLUSTER, clus_id);
        write_reg(REG_NODE, {$urandom, $urandom});
        write_reg(REG_MAXLEN, 64'd32);

        // Directed: start with HELLO out (a second start is ignored), a good
        // peer HELLO that is not a duplicate, then VERIFIED, then application
        // traffic with extreme bytes, an empty message, a tick and an undefined
        // operation.
        queue_op(OP_START, 8'h00, 1'b0, 8'h00);
        queue_op(OP_START, 8'h00, 1'b0, 8'h00);
        queue_hello(64'h1, clus_id, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 25);
        queue_header(32'd1);
        queue_byte(TYPE_VERIFIED);
        queue_header(32'd2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_header(32'd0);
        queue_op(OP_TICK, 8'h00, 1'b0, 8'h00);
        queue_op(op_t'(3'd7), 8'hFF, 1'b1, 8'hFF);

        // Long receiver hold-off with traffic still offered.
        queue_header(32'd8);
        for (int i = 0; i < 8; i++)
            queue_byte(8'($urandom));
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;

        // Random verified traffic, then a length above the limit.
        random_session(60, run_id, clus_id);
        queue_header(32'd33);
        wait_drained();

        // Later phases: the session is over; cover a zero timeout and limit, and rejects.
        write_reg(REG_TIMEOUT, 64'd0);
        write_reg(REG_MAXLEN, 64'd0);
        queue_op(OP_REJECT, 8'h00, 1'b0, 8'hFF);
        queue_op(OP_CLOSED, 8'h00, 1'b0, 8'h00);
        for (int n = 0; n < 60; n++)
            queue_op(op_t'($urandom_range(0, 7)), 8'($urandom), $urandom_range(0, 1),
                     8'($urandom));
        wait_drained();
        stim_done = 1'b1;

        $display("Run covered %0d input and %0d output transactions,", n_in_accepted,
                 n_out_seen);
        $display("with config phases, directed handshake and random session traffic.");
        if (mismatches == 0 && expected_out.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/fsh_pkg.sv
rtl/fsh_front.sv
rtl/fsh_back.sv
rtl/fsh_queue.sv
rtl/framed_session_handshake.sv
tb/framed_session_handshake_test.sv
